// ----- src/rltt_pkg.sv -----
package rltt_pkg;

    localparam int LINES_MAX_DEF = 4096;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_OUT_W = 12;
    localparam int OFFSET_W  = 12;
    localparam int BRIGHT_W  = 7;
    localparam int PERIOD_W  = 16;
    localparam int TURN_W    = 32;
    localparam int OUT_W     = 56;

    localparam logic [CFG_IDX_W-1:0] REG_LINES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'd65500;
    localparam logic [PERIOD_W-1:0] JUMP_LIMIT   = 16'd4;
    localparam logic [PERIOD_W-1:0] OFF_SCALE    = 16'd50000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd30000;
    localparam logic [PERIOD_W-1:0] OFF_RST      = 16'd29950;
    localparam int                  LINES_RST    = 1920;
    localparam logic [OFFSET_W-1:0] OFFSET_RST   = 12'd700;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 7'd100;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_TRIGGER = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUO,
        ST_DIVQ,
        ST_FILT,
        ST_MUL,
        ST_MULW,
        ST_DIVO,
        ST_DIVOW,
        ST_DONE
    } t_state;

    // divider: num[31:16] must be below den, quotient fits 16 bits
    typedef struct packed {
        logic                start;
        logic [TURN_W-1:0]   num;
        logic [PERIOD_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] a;
        logic [PERIOD_W-1:0] b;
    } t_mul_req;

endpackage

// ----- src/rltt_div.sv -----
module rltt_div
    import rltt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [PERIOD_W-1:0] o_quo
);

    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_lo;
    logic [PERIOD_W-1:0] r_den;
    logic [3:0]          r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [PERIOD_W:0]   w_trial;
    logic                w_qbit;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_lo[PERIOD_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[TURN_W-1:PERIOD_W];
            r_lo  <= i_req.num[PERIOD_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_qbit ? PERIOD_W'(w_trial - {1'b0, r_den}) : w_trial[PERIOD_W-1:0];
            r_lo  <= {r_lo[PERIOD_W-2:0], w_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_lo;

endmodule

// ----- src/rltt_mul.sv -----
module rltt_mul
    import rltt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output logic              o_done,
    output logic [TURN_W-1:0] o_prod
);

    logic [TURN_W-1:0]   r_acc;
    logic [TURN_W-1:0]   r_a;
    logic [PERIOD_W-1:0] r_b;
    logic [3:0]          r_cnt;
    logic                r_busy;
    logic                r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= TURN_W'(i_req.a);
            r_b   <= i_req.b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[TURN_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[PERIOD_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- src/rotation_line_timing_tracker_top.sv -----
// Line tick: the result is registered straight into the output register on accept; one tick per cycle
//   while the output side keeps taking items.
// Trigger: two 16-step serial divides and a 16-step shift-add multiply, run one after another
//   (quotient, then LED-off threshold); the quotient divide is skipped when the quotient clamps.
// Reset (i_rst_n, synchronous, active low) restores the configuration and timing state to
//   their defaults; no clearing pass, the block is ready the cycle after reset.
module rotation_line_timing_tracker_top
    import rltt_pkg::*;
#(
    parameter int MAX_LINES = LINES_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] partial_count
    input  logic                 s_axis_tuser,   // [0] command
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // [11:0] front_line, [23:12] back_line,
                                                 // [39:24] period_out, [55:40] off_threshold
);

    // lines register width; config field is 13 bits so never wider than that
    localparam int LPT_FULL = $clog2(MAX_LINES + 1);
    localparam int LPT_W    = (LPT_FULL > CFG_W) ? CFG_W : LPT_FULL;
    localparam int IDX_W    = LPT_W;
    localparam int LPT_RST  = (MAX_LINES < LINES_RST) ? MAX_LINES : LINES_RST;

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic [LPT_W-1:0]    r_lpt;
    logic [OFFSET_W-1:0] r_offset;
    logic [BRIGHT_W-1:0] r_bright;
    logic [TURN_W-1:0]   r_turn,   n_turn;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [PERIOD_W-1:0] r_off,    n_off;
    logic [PERIOD_W-1:0] r_quo,    n_quo;
    logic [IDX_W-1:0]    r_front,  n_front;
    logic [IDX_W-1:0]    r_back,   n_back;
    logic                r_out_valid, n_out_valid;
    logic [OUT_W-1:0]    r_out_data,  n_out_data;

    t_div_req            w_div_req;
    t_mul_req            w_mul_req;
    logic                w_div_done;
    logic [PERIOD_W-1:0] w_div_quo;
    logic                w_mul_done;
    logic [TURN_W-1:0]   w_mul_prod;

    logic                w_slot_free;
    logic                w_in_fire;

    rltt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    rltt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // output register frees the input side as soon as the result is taken
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_slot_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    // ---------------------------------------------------------------
    // configuration writes, lines and brightness with range saturation
    // ---------------------------------------------------------------
    logic [16:0] w_cfg_lines;

    always_comb begin
        if (i_cfg_wdata < CFG_W'(2)) begin
            w_cfg_lines = 17'd2;
        end else if (17'(i_cfg_wdata) > 17'(MAX_LINES)) begin
            w_cfg_lines = 17'(MAX_LINES);
        end else begin
            w_cfg_lines = 17'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpt    <= LPT_W'(LPT_RST);
            r_offset <= OFFSET_RST;
            r_bright <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                REG_LINES:  r_lpt    <= LPT_W'(w_cfg_lines);
                REG_OFFSET: r_offset <= i_cfg_wdata[OFFSET_W-1:0];
                REG_BRIGHT: r_bright <= (i_cfg_wdata[BRIGHT_W-1:0] > BRIGHT_MAX) ?
                                        BRIGHT_MAX : i_cfg_wdata[BRIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // datapath helpers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0]    w_lpt13;
    logic [CFG_W-1:0]    w_front13;
    logic [CFG_W-1:0]    w_back13;
    logic [CFG_W-1:0]    w_rel_front;
    logic [CFG_W:0]      w_rel_sum;
    logic [CFG_W:0]      w_rel_back;
    logic [IDX_W:0]      w_front_inc;
    logic [IDX_W:0]      w_back_inc;
    logic [TURN_W:0]     w_turn_sum;
    logic [TURN_W-1:0]   w_turn_sat;
    logic [PERIOD_W-1:0] w_addend;
    logic [PERIOD_W-1:0] w_q;
    logic [PERIOD_W-1:0] w_diff;
    logic [20:0]         w_filt;
    logic [PERIOD_W-1:0] w_new_period;
    logic [13:0]         w_bsq;
    logic [PERIOD_W-1:0] w_k;
    logic                w_quo_sat;

    assign w_lpt13   = CFG_W'(r_lpt);
    assign w_front13 = CFG_W'(r_front);
    assign w_back13  = CFG_W'(r_back);

    // tick advance; an index left beyond a shrunk turn wraps to zero too
    assign w_front_inc = {1'b0, r_front} + (IDX_W+1)'(1);
    assign w_back_inc  = {1'b0, r_back} + (IDX_W+1)'(1);

    // reload at trigger: offset saturates below the turn, back half a turn on
    assign w_rel_front = ({1'b0, r_offset} >= w_lpt13) ? (w_lpt13 - CFG_W'(1))
                                                       : {1'b0, r_offset};
    assign w_rel_sum   = {1'b0, w_rel_front} + {2'b00, w_lpt13[CFG_W-1:1]};
    assign w_rel_back  = (w_rel_sum >= {1'b0, w_lpt13}) ? (w_rel_sum - {1'b0, w_lpt13})
                                                        : w_rel_sum;

    // saturating accumulate, period on tick and partial count on trigger
    assign w_addend   = (s_axis_tuser == CMD_TRIGGER) ? s_axis_tdata : r_period;
    assign w_turn_sum = {1'b0, r_turn} + (TURN_W+1)'(w_addend);
    assign w_turn_sat = w_turn_sum[TURN_W] ? '1 : w_turn_sum[TURN_W-1:0];

    // quotient above 16 bits only ever clamps, so skip the divide then
    assign w_quo_sat = (r_turn[TURN_W-1:PERIOD_W] >= PERIOD_W'(r_lpt));

    // jump or (15*old + new)/16
    assign w_q          = (r_quo > PERIOD_MAX) ? PERIOD_MAX : r_quo;
    assign w_diff       = (w_q > r_period) ? (w_q - r_period) : (r_period - w_q);
    assign w_filt       = (21'(r_period) << 4) - 21'(r_period) + 21'(w_q);
    assign w_new_period = (w_diff > JUMP_LIMIT) ? w_q : w_filt[19:4];

    // off threshold scale factor, 50000 - b^2 (b <= 100)
    assign w_bsq = 14'(r_bright) * 14'(r_bright);
    assign w_k   = OFF_SCALE - PERIOD_W'(w_bsq);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_turn      = r_turn;
        n_period    = r_period;
        n_off       = r_off;
        n_quo       = r_quo;
        n_front     = r_front;
        n_back      = r_back;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_div_req   = '0;
        w_mul_req   = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_turn = w_turn_sat;
                    if (s_axis_tuser == CMD_TICK) begin
                        n_out_valid = 1'b1;
                        n_out_data  = {r_off, r_period, w_back13[IDX_OUT_W-1:0],
                                       w_front13[IDX_OUT_W-1:0]};
                        n_front = (w_front_inc >= (IDX_W+1)'(r_lpt)) ? '0
                                                                     : w_front_inc[IDX_W-1:0];
                        n_back  = (w_back_inc >= (IDX_W+1)'(r_lpt)) ? '0
                                                                    : w_back_inc[IDX_W-1:0];
                    end else begin
                        n_state = ST_QUO;
                    end
                end
            end
            ST_QUO: begin
                if (w_quo_sat) begin
                    n_quo   = PERIOD_MAX;
                    n_state = ST_FILT;
                end else begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = r_turn;
                    w_div_req.den   = PERIOD_W'(r_lpt);
                    n_state         = ST_DIVQ;
                end
            end
            ST_DIVQ: begin
                if (w_div_done) begin
                    n_quo   = w_div_quo;
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                n_period = w_new_period;
                n_turn   = '0;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                w_mul_req.start = 1'b1;
                w_mul_req.a     = r_period;
                w_mul_req.b     = w_k;
                n_state         = ST_MULW;
            end
            ST_MULW: begin
                if (w_mul_done) begin
                    n_state = ST_DIVO;
                end
            end
            ST_DIVO: begin
                // product / 50000 stays below 2^16, so the high half is below the divisor
                w_div_req.start = 1'b1;
                w_div_req.num   = w_mul_prod;
                w_div_req.den   = OFF_SCALE;
                n_state         = ST_DIVOW;
            end
            ST_DIVOW: begin
                if (w_div_done) begin
                    n_off   = w_div_quo;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_front     = IDX_W'(w_rel_front);
                    n_back      = IDX_W'(w_rel_back);
                    n_out_valid = 1'b1;
                    n_out_data  = {r_off, r_period, w_rel_back[IDX_OUT_W-1:0],
                                   w_rel_front[IDX_OUT_W-1:0]};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_turn      <= '0;
            r_period    <= PERIOD_RST;
            r_off       <= OFF_RST;
            r_front     <= '0;
            r_back      <= IDX_W'(LPT_RST / 2);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_turn      <= n_turn;
            r_period    <= n_period;
            r_off       <= n_off;
            r_front     <= n_front;
            r_back      <= n_back;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_out_data <= n_out_data;
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_trig_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && s_axis_tuser == CMD_TRIGGER) |=> (r_state == ST_QUO))
        else $error("trigger did not start the period update");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIVQ || r_state == ST_DIVOW))
        else $error("divider finished outside a wait state");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == ST_MULW))
        else $error("multiplier finished outside its wait state");

    a_reload_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_slot_free) |=>
            (CFG_W'(r_front) < w_lpt13 && CFG_W'(r_back) < w_lpt13))
        else $error("reloaded line index outside the turn");

    a_period_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILT) |=> (r_period <= PERIOD_MAX))
        else $error("line period above clamp");

endmodule

// ----- sim/tb_rotation_line_timing_tracker_top.sv -----
`timescale 1ns / 1ps

module tb_rotation_line_timing_tracker_top;
    import rltt_pkg::*;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 90;
    localparam int PRINT_LIMIT   = 50;

    // one result item, fields as the block reports them
    typedef struct packed {
        logic [IDX_OUT_W-1:0] front;
        logic [IDX_OUT_W-1:0] back;
        logic [PERIOD_W-1:0]  period;
        logic [PERIOD_W-1:0]  off_thr;
    } t_line_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;   // [15:0] partial_count
    logic                 s_axis_tuser = 1'b0; // [0] command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // [11:0] front, [23:12] back,
                                               // [39:24] period, [55:40] off threshold

    rotation_line_timing_tracker_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line timing predictor: own copy of registers and timing state
    // ------------------------------------------------------------------
    logic [12:0]          lines_cfg;
    logic [OFFSET_W-1:0]  offset_cfg;
    logic [BRIGHT_W-1:0]  bright_cfg;
    logic [TURN_W-1:0]    turn_acc;
    logic [PERIOD_W-1:0]  period_now;
    logic [PERIOD_W-1:0]  off_now;
    logic [IDX_OUT_W-1:0] front_idx;
    logic [IDX_OUT_W-1:0] back_idx;

    t_line_result expected_lines[$];
    int           mismatches = 0;
    int           items_sent = 0;
    int           cycle_count = 0;
    bit           idle_on = 1'b0;
    int           stall_left = 0;

    function automatic void reset_line_timing();
        lines_cfg  = 13'(LINES_RST);
        offset_cfg = OFFSET_RST;
        bright_cfg = '0;
        turn_acc   = '0;
        period_now = PERIOD_RST;
        off_now    = OFF_RST;
        front_idx  = '0;
        back_idx   = 12'(LINES_RST / 2);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] addr,
                                           input logic [CFG_W-1:0] data);
        case (addr)
            REG_LINES: begin
                if (data < 13'd2)
                    lines_cfg = 13'd2;
                else if (data > 13'(LINES_MAX_DEF))
                    lines_cfg = 13'(LINES_MAX_DEF);
                else
                    lines_cfg = data;
            end
            REG_OFFSET: offset_cfg = data[OFFSET_W-1:0];
            REG_BRIGHT: begin
                bright_cfg = (data[BRIGHT_W-1:0] > BRIGHT_MAX) ? BRIGHT_MAX
                                                               : data[BRIGHT_W-1:0];
            end
            default: ;  // ignored
        endcase
    endfunction

    // saturating accumulate into the turn timer
    function automatic logic [TURN_W-1:0] add_turn(input logic [TURN_W-1:0] a,
                                                    input logic [TURN_W-1:0] b);
        logic [TURN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TURN_W] ? {TURN_W{1'b1}} : s[TURN_W-1:0];
    endfunction

    function automatic logic [IDX_OUT_W-1:0] wrap_next(input logic [IDX_OUT_W-1:0] idx);
        logic [12:0] n;
        n = 13'(idx) + 13'd1;
        return (n >= lines_cfg) ? '0 : n[IDX_OUT_W-1:0];
    endfunction

    function automatic t_line_result advance_line_timing(input logic cmd,
                                                         input logic [15:0] partial);
        t_line_result r;
        logic [31:0]  quo;
        logic [31:0]  diff;
        logic [31:0]  scale;
        logic [47:0]  prod;
        logic [12:0]  f13;
        logic [12:0]  b13;
        if (cmd == CMD_TICK) begin
            turn_acc  = add_turn(turn_acc, 32'(period_now));
            r         = '{front_idx, back_idx, period_now, off_now};
            front_idx = wrap_next(front_idx);
            back_idx  = wrap_next(back_idx);
            return r;
        end
        turn_acc = add_turn(turn_acc, 32'(partial));
        quo = turn_acc / 32'(lines_cfg);
        if (quo > 32'(PERIOD_MAX))
            quo = 32'(PERIOD_MAX);
        diff = (quo > 32'(period_now)) ? quo - 32'(period_now) : 32'(period_now) - quo;
        if (diff > 32'(JUMP_LIMIT))
            period_now = quo[PERIOD_W-1:0];
        else
            period_now = 16'((32'd15 * 32'(period_now) + quo) / 32'd16);
        // off threshold: period scaled by (1 - b^2/50000), exact floor
        scale   = 32'(OFF_SCALE) - 32'(bright_cfg) * 32'(bright_cfg);
        prod    = 48'(period_now) * 48'(scale);
        off_now = 16'(prod / 48'(OFF_SCALE));
        turn_acc = '0;
        f13 = (13'(offset_cfg) >= lines_cfg) ? lines_cfg - 13'd1 : 13'(offset_cfg);
        b13 = f13 + (lines_cfg >> 1);
        if (b13 >= lines_cfg)
            b13 = b13 - lines_cfg;
        front_idx = f13[IDX_OUT_W-1:0];
        back_idx  = b13[IDX_OUT_W-1:0];
        return '{front_idx, back_idx, period_now, off_now};
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // results are taken at the rising edge, compared against the oldest expectation
    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_lines.size() == 0) begin
                report_mismatch("unexpected item", longint'(m_axis_tdata), 0);
            end else begin
                want = expected_lines.pop_front();
                if (m_axis_tdata[11:0] !== want.front)
                    report_mismatch("front_line", m_axis_tdata[11:0], want.front);
                if (m_axis_tdata[23:12] !== want.back)
                    report_mismatch("back_line", m_axis_tdata[23:12], want.back);
                if (m_axis_tdata[39:24] !== want.period)
                    report_mismatch("period_out", m_axis_tdata[39:24], want.period);
                if (m_axis_tdata[55:40] !== want.off_thr)
                    report_mismatch("off_threshold", m_axis_tdata[55:40], want.off_thr);
            end
        end
    end

    // result side back-pressure: random stall bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_rotation_line_timing_tracker_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left just after a falling edge.
    // ------------------------------------------------------------------

    // tvalid stays high on return so back-to-back items need no re-raise
    task automatic send_item(input logic cmd, input logic [15:0] partial);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= partial;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_lines.push_back(advance_line_timing(cmd, partial));
        items_sent++;
        @(negedge i_clk);
    endtask

    // partial count is don't-care on a tick, so it is always random
    task automatic send_tick();
        send_item(CMD_TICK, 16'($urandom));
    endtask

    // trigger whose partial count aims the quotient at period + step
    task automatic send_trigger_aimed(input int step);
        longint part;
        part = (longint'(period_now) + step) * longint'(lines_cfg)
             + longint'($urandom_range(0, lines_cfg - 1)) - longint'(turn_acc);
        if (part < 0)
            part = 0;
        if (part > 65535)
            part = 65535;
        send_item(CMD_TRIGGER, part[15:0]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] data,
                             input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(addr, data);
        @(negedge i_clk);
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    // stop the stream and wait until every expected item is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_lines.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // defaults straight out of reset; partial count on a tick is ignored
    task automatic test_reset_values();
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_TICK, 16'hFFFF);
    endtask

    // lines below 2, offset past the turn, brightness above 100, unknown index
    task automatic test_register_limits();
        wait_drained();
        write_reg(REG_LINES, 13'd0, 1'b0);
        write_reg(REG_OFFSET, 13'h0FFF, 1'b0);
        write_reg(REG_BRIGHT, 13'h007F, 1'b0);
        write_reg(REG_UNUSED, 13'h1FFF, 1'b1);
        send_item(CMD_TRIGGER, 16'hFFFF);
        send_tick();
        send_tick();
    endtask

    // top of the line range, then shrink the turn under the running indices
    task automatic test_index_wrap();
        wait_drained();
        write_reg(REG_LINES, 13'h1FFF, 1'b0);
        write_reg(REG_OFFSET, 13'h1FFF, 1'b0);
        write_reg(REG_BRIGHT, 13'd0, 1'b1);
        send_item(CMD_TRIGGER, 16'h0000);
        send_tick();
        wait_drained();
        write_reg(REG_LINES, 13'd100, 1'b1);
        send_tick();
        send_tick();
    endtask

    // quotient clamp, then the filter band edges and the jump just past them
    task automatic test_period_update();
        wait_drained();
        write_reg(REG_LINES, 13'd1, 1'b0);
        write_reg(REG_OFFSET, 13'd0, 1'b0);
        write_reg(REG_BRIGHT, 13'd100, 1'b1);
        while (period_now != PERIOD_MAX) begin
            repeat (3) send_tick();
            send_item(CMD_TRIGGER, 16'hFFFF);
        end
        send_trigger_aimed(20000 - int'(period_now));
        send_trigger_aimed(4);
        send_trigger_aimed(-4);
        send_trigger_aimed(5);
        send_trigger_aimed(-5);
    endtask

    // long turn at the largest period with the most lines per turn
    task automatic test_long_turn();
        idle_on = 1'b0;
        wait_drained();
        write_reg(REG_LINES, 13'd2, 1'b0);
        write_reg(REG_BRIGHT, 13'd37, 1'b1);
        while (period_now != PERIOD_MAX) begin
            repeat (3) send_tick();
            send_item(CMD_TRIGGER, 16'hFFFF);
        end
        wait_drained();
        write_reg(REG_LINES, 13'd4096, 1'b1);
        repeat (100) send_tick();
        send_item(CMD_TRIGGER, 16'($urandom));
    endtask

    task automatic write_random_config();
        logic [CFG_W-1:0] lines_w;
        logic [CFG_W-1:0] offset_w;
        logic [CFG_W-1:0] bright_w;
        case ($urandom_range(0, 9))
            0: lines_w = 13'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: lines_w = 13'd0;
                    1: lines_w = 13'd1;
                    2: lines_w = 13'd4096;
                    default: lines_w = 13'h1FFF;
                endcase
            end
            default: lines_w = 13'($urandom_range(2, 24));
        endcase
        offset_w = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 30)) : 13'($urandom);
        case ($urandom_range(0, 3))
            0: bright_w = 13'd0;
            1: bright_w = 13'd100;
            default: bright_w = 13'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 13'($urandom), 1'b0);
        write_reg(REG_LINES, lines_w, 1'b0);
        write_reg(REG_OFFSET, offset_w, 1'b0);
        write_reg(REG_BRIGHT, bright_w, 1'b1);
    endtask

    // mostly whole turns (lines-1 ticks when lines <= 48, then an aimed trigger),
    // the rest short turns, lone triggers and stray items
    task automatic test_random_turns();
        int target;
        int n_ticks;
        int step;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_on = 1'b0;
            wait_drained();
            write_random_config();
            // last stretch of the run goes without idling
            idle_on = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                case ($urandom_range(0, 9))
                    7: send_item(1'($urandom), 16'($urandom));
                    8: begin
                        n_ticks = $urandom_range(0, 48);
                        repeat (n_ticks) send_tick();
                        send_item(CMD_TRIGGER, 16'($urandom));
                    end
                    9: send_item(CMD_TRIGGER, 16'($urandom));
                    default: begin
                        n_ticks = (lines_cfg <= 13'd48) ? int'(lines_cfg) - 1
                                                        : $urandom_range(0, 48);
                        repeat (n_ticks) send_tick();
                        case ($urandom_range(0, 4))
                            0, 1: step = int'($urandom_range(0, 8)) - 4;
                            2: begin
                                step = $urandom_range(5, 40);
                                if ($urandom_range(0, 1) == 0)
                                    step = -step;
                            end
                            3: step = int'($urandom_range(0, 2000)) - 1000;
                            default: step = 100000;
                        endcase
                        send_trigger_aimed(step);
                    end
                endcase
            end
        end
    endtask

    initial begin
        reset_line_timing();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        test_reset_values();
        test_register_limits();
        test_index_wrap();
        test_period_update();
        test_long_turn();
        test_random_turns();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_lines.size() == 0)
            $display("tb_rotation_line_timing_tracker_top OK");
        else
            $display("tb_rotation_line_timing_tracker_top NOT OK");
        $finish;
    end

endmodule
